[rtl/rrid_pkg.sv]
// ----------------------------------------------------------------------------
// rrid_pkg
// Shared types and constants of the row-based run-length image decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rrid_pkg;

  // header is four bytes: width lo, width hi, rows lo, rows hi
  localparam logic [2:0] HeaderBytes = 3'd4;

  // code byte fields
  localparam logic [1:0] LiteralType = 2'b11;

  // clamps on the configuration registers
  localparam logic [15:0] MaxHeight = 16'd1024;
  localparam logic [15:0] MaxStride = 16'd4096;

  // configuration register map
  localparam int unsigned CfgAddrW = 1;
  localparam int unsigned CfgDataW = 13;
  localparam logic [CfgAddrW-1:0] RegMaxRows   = 1'b0;
  localparam logic [CfgAddrW-1:0] RegRowStride = 1'b1;

  // configuration reset values
  localparam logic [10:0] MaxRowsReset   = 11'd200;
  localparam logic [12:0] RowStrideReset = 13'd320;

  // one run handed from the front to the back
  typedef struct packed {
    logic [15:0] row;
    logic [15:0] col;
    logic [6:0]  len;
    logic [7:0]  value;
  } rrid_cmd_t;

  // back end sequencer
  typedef enum logic [0:0] {
    BkIdle,
    BkRun
  } rrid_back_e;

endpackage

`default_nettype wire

[rtl/rrid_if.sv]
// ----------------------------------------------------------------------------
// rrid interfaces
// Valid/ready channels for input bytes, output pixels and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

// compressed byte channel
interface rrid_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// decoded pixel channel
interface rrid_out_if;
  logic        valid;
  logic        ready;
  logic [22:0] pixel_offset;
  logic [7:0]  pixel_value;
  logic        run_last;

  modport source (output valid, output pixel_offset, output pixel_value,
                  output run_last, input ready);
  modport sink   (input valid, input pixel_offset, input pixel_value,
                  input run_last, output ready);
endinterface

// register write channel
interface rrid_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  addr;
  logic [12:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

[rtl/rrid_front.sv]
// ----------------------------------------------------------------------------
// rrid_front
// Takes compressed bytes, parses the header, classifies code and fill bytes
// and tracks row position; hands complete runs to the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rrid_front
  import rrid_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rrid_in_if.sink    in_i,
  input  wire logic  [15:0] row_limit_i,
  output rrid_cmd_t  cmd_o,
  output logic       cmd_push_o,
  input  wire logic  cmd_full_i
);

  logic [2:0]  hdr_idx_q, hdr_idx_d;
  logic [15:0] row_width_q, row_width_d;
  logic [15:0] hdr_rows_q, hdr_rows_d;
  logic [15:0] cur_row_q, cur_row_d;
  logic [15:0] row_left_q, row_left_d;
  logic [6:0]  pend_q, pend_d;
  logic        await_q, await_d;
  logic        done_q, done_d;

  logic        accept;
  logic [7:0]  b;
  logic [6:0]  code_len;
  logic [6:0]  clamp_len;
  logic [6:0]  run_len;
  logic [15:0] left_after;
  logic        image_end;

  // intake stalls only on a full queue
  assign in_i.ready = !cmd_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.data_byte;

  // run length from the code byte, clamped to the rest of the row
  assign code_len  = {1'b0, b[5:0]} + 7'd1;
  assign clamp_len = ({9'd0, code_len} > row_left_q) ? row_left_q[6:0] : code_len;
  assign run_len   = await_q ? pend_q : clamp_len;
  assign left_after = row_left_q - {9'd0, run_len};

  assign image_end = (row_width_q == 16'd0) || (cur_row_q >= hdr_rows_q)
                     || (cur_row_q >= row_limit_i);

  // run command contents
  assign cmd_o.row   = cur_row_q;
  assign cmd_o.col   = row_width_q - row_left_q;
  assign cmd_o.len   = run_len;
  assign cmd_o.value = b;

  // byte classification and row tracking
  always_comb begin
    hdr_idx_d   = hdr_idx_q;
    row_width_d = row_width_q;
    hdr_rows_d  = hdr_rows_q;
    cur_row_d   = cur_row_q;
    row_left_d  = row_left_q;
    pend_d      = pend_q;
    await_d     = await_q;
    done_d      = done_q;
    cmd_push_o  = 1'b0;

    if (accept) begin
      priority if (hdr_idx_q != HeaderBytes) begin
        hdr_idx_d = hdr_idx_q + 3'd1;
        unique case (hdr_idx_q[1:0])
          2'd0: row_width_d = {8'd0, b};
          2'd1: row_width_d = {b, row_width_q[7:0]};
          2'd2: hdr_rows_d  = {8'd0, b};
          default: begin
            hdr_rows_d = {b, hdr_rows_q[7:0]};
            row_left_d = row_width_q;
          end
        endcase
      end else if (await_q) begin
        cmd_push_o = 1'b1;
        await_d    = 1'b0;
        pend_d     = 7'd0;
      end else if (!done_q) begin
        if (image_end) begin
          done_d = 1'b1;
        end else if (b[7:6] == LiteralType) begin
          cmd_push_o = 1'b1;
        end else begin
          pend_d  = clamp_len;
          await_d = 1'b1;
        end
      end

      // a run leaves the row; a full row steps to the next
      if (cmd_push_o) begin
        if (left_after == 16'd0) begin
          cur_row_d  = cur_row_q + 16'd1;
          row_left_d = row_width_q;
        end else begin
          row_left_d = left_after;
        end
      end

      // end of resource returns to the start
      if (in_i.last_byte) begin
        hdr_idx_d   = 3'd0;
        row_width_d = 16'd0;
        hdr_rows_d  = 16'd0;
        cur_row_d   = 16'd0;
        row_left_d  = 16'd0;
        pend_d      = 7'd0;
        await_d     = 1'b0;
        done_d      = 1'b0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_idx_q   <= 3'd0;
      row_width_q <= 16'd0;
      hdr_rows_q  <= 16'd0;
      cur_row_q   <= 16'd0;
      row_left_q  <= 16'd0;
      pend_q      <= 7'd0;
      await_q     <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      hdr_idx_q   <= hdr_idx_d;
      row_width_q <= row_width_d;
      hdr_rows_q  <= hdr_rows_d;
      cur_row_q   <= cur_row_d;
      row_left_q  <= row_left_d;
      pend_q      <= pend_d;
      await_q     <= await_d;
      done_q      <= done_d;
    end
  end

`ifndef ASSERT_OFF
  // a pushed run is never empty
  a_push_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push_o |-> cmd_o.len != 7'd0)
    else $error("rrid_front: zero-length run pushed");
`endif

endmodule

`default_nettype wire

[rtl/rrid_queue.sv]
// ----------------------------------------------------------------------------
// rrid_queue
// Two-entry queue of run commands between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module rrid_queue
  import rrid_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire rrid_cmd_t  cmd_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output logic            empty_o,
  output rrid_cmd_t       cmd_o
);

  rrid_cmd_t  entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign cmd_o   = entry_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

`ifndef ASSERT_OFF
  // no push into a full queue, no pop from an empty one
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("rrid_queue: push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("rrid_queue: pop while empty");
`endif

endmodule

`default_nettype wire

[rtl/rrid_back.sv]
// ----------------------------------------------------------------------------
// rrid_back
// Takes run commands, forms the frame offset of the run start, then emits
// one pixel word per cycle into the output register while it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module rrid_back
  import rrid_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire rrid_cmd_t  cmd_i,
  input  wire logic       empty_i,
  output logic            pop_o,
  input  wire logic [12:0] stride_i,
  rrid_out_if.source      out_o
);

  rrid_back_e  state_q, state_d;
  logic [22:0] base_q, base_d;
  logic [6:0]  left_q, left_d;
  logic [7:0]  value_q, value_d;

  logic        out_valid_q, out_valid_d;
  logic [22:0] out_off_q, out_off_d;
  logic [7:0]  out_val_q, out_val_d;
  logic        out_last_q, out_last_d;

  logic        out_free;
  logic        fire;
  logic [28:0] product;

  assign out_free = !out_valid_q || out_o.ready;
  assign product  = {13'd0, cmd_i.row} * {16'd0, stride_i};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkIdle: if (!empty_i) state_d = BkRun;
      BkRun:  if (out_free && left_q == 7'd1) state_d = BkIdle;
      default: state_d = BkIdle;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop_o = 1'b0;
    fire  = 1'b0;
    unique case (state_q)
      BkIdle: pop_o = !empty_i;
      BkRun:  fire  = out_free;
      default: ;
    endcase
  end

  // run datapath and output register
  always_comb begin
    base_d      = base_q;
    left_d      = left_q;
    value_d     = value_q;
    out_valid_d = out_valid_q;
    out_off_d   = out_off_q;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      base_d  = product[22:0] + {7'd0, cmd_i.col};
      left_d  = cmd_i.len;
      value_d = cmd_i.value;
    end
    if (fire) begin
      out_valid_d = 1'b1;
      out_off_d   = base_q;
      out_val_d   = value_q;
      out_last_d  = left_q == 7'd1;
      base_d      = base_q + 23'd1;
      left_d      = left_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      out_valid_q <= 1'b0;
      left_q      <= 7'd0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      left_q      <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q    <= base_d;
    value_q   <= value_d;
    out_off_q <= out_off_d;
    out_val_q <= out_val_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pixel_offset = out_off_q;
  assign out_o.pixel_value  = out_val_q;
  assign out_o.run_last     = out_last_q;

`ifndef ASSERT_OFF
  // a run in progress always has pixels left
  a_run_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BkRun |-> left_q != 7'd0)
    else $error("rrid_back: run state with nothing left");
  // the final pixel of a run returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && left_q == 7'd1 |=> state_q == BkIdle && out_o.run_last)
    else $error("rrid_back: run end not followed by idle");
`endif

endmodule

`default_nettype wire

[rtl/row_rle_image_decoder.sv]
// ----------------------------------------------------------------------------
// row_rle_image_decoder
// Row-based run-length image decoder: compressed bytes in, pixel words with
// frame offsets out.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while the two-entry run queue has room.
// A run of n pixels (1 to 64) holds the back end: the idle state pops it and
// forms the start offset with the row times stride multiplier, then the run
// state sends one pixel word per cycle as the output side takes them, so
// sustained intake during pixel output is set by that one-pixel-per-cycle port.
// Register writes are taken at any time and have ready tied high.
`default_nettype none

module row_rle_image_decoder
  import rrid_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rrid_cfg_if.sink   cfg_i,
  rrid_in_if.sink    in_i,
  rrid_out_if.source out_o
);

  logic [10:0] max_rows_q;
  logic [12:0] row_stride_q;
  logic [15:0] row_limit;
  logic [15:0] stride_clamp;
  logic [12:0] stride_eff;

  rrid_cmd_t   push_cmd;
  rrid_cmd_t   head_cmd;
  logic        push;
  logic        pop;
  logic        full;
  logic        empty;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rows_q   <= MaxRowsReset;
      row_stride_q <= RowStrideReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.addr)
        RegMaxRows:   max_rows_q   <= cfg_i.data[10:0];
        RegRowStride: row_stride_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // clamp limits to their maxima
  assign row_limit    = ({5'd0, max_rows_q} > MaxHeight) ? MaxHeight : {5'd0, max_rows_q};
  assign stride_clamp = ({3'd0, row_stride_q} > MaxStride) ? MaxStride
                                                            : {3'd0, row_stride_q};
  assign stride_eff   = stride_clamp[12:0];

  rrid_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .row_limit_i (row_limit),
    .cmd_o       (push_cmd),
    .cmd_push_o  (push),
    .cmd_full_i  (full)
  );

  rrid_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (head_cmd)
  );

  rrid_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (head_cmd),
    .empty_i  (empty),
    .pop_o    (pop),
    .stride_i (stride_eff),
    .out_o    (out_o)
  );

endmodule

`default_nettype wire
